@@ design/atilt_pkg.sv @@
// ----------------------------------------------------------------------------
// atilt_pkg
// Shared widths, register indexes, stage types and the arctangent table for
// the accelerometer tilt angle pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package atilt_pkg;

    // sample and result formats
    localparam int SAMPLE_W   = 16;
    localparam int ANGLE_FRAC = 7;
    localparam int ALT_W      = 15;
    localparam int AZ_W       = 16;

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = CFG_IDX_W'(2);

    // front end
    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int MAG_W  = SAMPLE_W;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = SQ_W + 1;

    // square root
    localparam int RAD_W  = 62;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int KN     = 5;
    localparam int K_W    = KN;

    // arctangent
    localparam int NORM_W   = 59;
    localparam int NN       = 6;
    localparam int NSH_W    = NN;
    localparam int CORD_W   = NORM_W + 4;
    localparam int STEPS    = 24;
    localparam int STEP_W   = 5;
    localparam int ACC_FRAC = 20;
    localparam int ANG_W    = 29;
    localparam int TH_W     = ANG_W - 1;
    localparam int RND_SH   = ACC_FRAC - ANGLE_FRAC;

    localparam logic [TH_W-1:0] DEG90  = TH_W'(90 * (2 ** ACC_FRAC));
    localparam logic [TH_W-1:0] DEG180 = TH_W'(180 * (2 ** ACC_FRAC));

    typedef struct packed {
        logic y_neg;
        logic x_neg;
        logic z_neg;
        logic y_zero;
        logic x_zero;
        logic z_zero;
        logic s_zero;
    } flag_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [ROOT_W-1:0] root;
        logic [REM_W-1:0]  rem;
        logic [MAG_W-1:0]  ax;
        logic [MAG_W-1:0]  ay;
        logic [MAG_W-1:0]  az;
        logic [K_W-1:0]    k;
        flag_t             flags;
    } sq_t;

    typedef struct packed {
        logic [NORM_W-1:0] alt_a;
        logic [NORM_W-1:0] alt_b;
        logic [NORM_W-1:0] az_a;
        logic [NORM_W-1:0] az_b;
        flag_t             flags;
    } norm_t;

    typedef struct packed {
        logic signed [CORD_W-1:0] px;
        logic signed [CORD_W-1:0] py;
        logic signed [ANG_W-1:0]  ang;
    } lane_t;

    typedef struct packed {
        lane_t alt;
        lane_t az;
        flag_t flags;
    } cord_t;

    // atan(2^-i) in degrees with ACC_FRAC fraction bits
    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
        logic signed [ANG_W-1:0] r;
        case (i)
            5'd0:    r = ANG_W'(47185920);
            5'd1:    r = ANG_W'(27855475);
            5'd2:    r = ANG_W'(14718068);
            5'd3:    r = ANG_W'(7471121);
            5'd4:    r = ANG_W'(3750058);
            5'd5:    r = ANG_W'(1876857);
            5'd6:    r = ANG_W'(938658);
            5'd7:    r = ANG_W'(469357);
            5'd8:    r = ANG_W'(234682);
            5'd9:    r = ANG_W'(117342);
            5'd10:   r = ANG_W'(58671);
            5'd11:   r = ANG_W'(29335);
            5'd12:   r = ANG_W'(14668);
            5'd13:   r = ANG_W'(7334);
            5'd14:   r = ANG_W'(3667);
            5'd15:   r = ANG_W'(1833);
            5'd16:   r = ANG_W'(917);
            5'd17:   r = ANG_W'(458);
            5'd18:   r = ANG_W'(229);
            5'd19:   r = ANG_W'(115);
            5'd20:   r = ANG_W'(57);
            5'd21:   r = ANG_W'(29);
            5'd22:   r = ANG_W'(14);
            5'd23:   r = ANG_W'(7);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ design/atilt_if.sv @@
// ----------------------------------------------------------------------------
// atilt_if
// Valid/ready channels for accelerometer samples and tilt angle results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface atilt_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [atilt_pkg::SAMPLE_W-1:0] accel_x;
    logic signed [atilt_pkg::SAMPLE_W-1:0] accel_y;
    logic signed [atilt_pkg::SAMPLE_W-1:0] accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink (input valid, input accel_x, input accel_y, input accel_z,
                  output ready);
endinterface

interface atilt_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [atilt_pkg::ALT_W-1:0] altitude_deg;
    logic signed [atilt_pkg::AZ_W-1:0]  azimuth_deg;

    modport source (output valid, output altitude_deg, output azimuth_deg, input ready);
    modport sink (input valid, input altitude_deg, input azimuth_deg, output ready);
endinterface

@@ design/atilt_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// atilt_sqrt_cell
// One digit of the restoring square root: takes two radicand bits, yields
// one root bit and hands the partial root and remainder to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module atilt_sqrt_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           i_valid,
    input  atilt_pkg::sq_t i_data,
    output logic           o_valid,
    output atilt_pkg::sq_t o_data
);
    import atilt_pkg::*;

    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             ge;
    logic             valid_reg;
    sq_t              data_reg;
    sq_t              data_next;

    always_comb
    begin
        rem_sh         = {i_data.rem, i_data.rad[RAD_W-1 -: 2]};
        trial          = {2'b00, i_data.root, 2'b01};
        diff           = rem_sh - trial;
        ge             = (rem_sh >= trial);
        data_next      = i_data;
        data_next.rad  = {i_data.rad[RAD_W-3:0], 2'b00};
        data_next.root = {i_data.root[ROOT_W-2:0], ge};
        data_next.rem  = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= i_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign o_valid = valid_reg;
    assign o_data  = data_reg;

endmodule

@@ design/atilt_norm_cell.sv @@
// ----------------------------------------------------------------------------
// atilt_norm_cell
// One step of the arctangent operand normalizer: shifts each operand pair
// left by a fixed amount when that keeps both below the working range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module atilt_norm_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic [atilt_pkg::NSH_W-1:0] amount,
    input  logic                        i_valid,
    input  atilt_pkg::norm_t            i_data,
    output logic                        o_valid,
    output atilt_pkg::norm_t            o_data
);
    import atilt_pkg::*;

    logic  alt_go;
    logic  az_go;
    logic  valid_reg;
    norm_t data_reg;
    norm_t data_next;

    always_comb
    begin
        alt_go    = (((i_data.alt_a | i_data.alt_b) >> (NORM_W - int'(amount))) == '0);
        az_go     = (((i_data.az_a | i_data.az_b) >> (NORM_W - int'(amount))) == '0);
        data_next = i_data;
        if (alt_go)
        begin
            data_next.alt_a = i_data.alt_a << amount;
            data_next.alt_b = i_data.alt_b << amount;
        end
        if (az_go)
        begin
            data_next.az_a = i_data.az_a << amount;
            data_next.az_b = i_data.az_b << amount;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= i_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign o_valid = valid_reg;
    assign o_data  = data_reg;

endmodule

@@ design/atilt_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// atilt_cordic_cell
// One vectoring CORDIC iteration for both the altitude and azimuth lanes,
// accumulating the rotation angle in degrees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module atilt_cordic_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic [atilt_pkg::STEP_W-1:0] step,
    input  logic                         i_valid,
    input  atilt_pkg::cord_t             i_data,
    output logic                         o_valid,
    output atilt_pkg::cord_t             o_data
);
    import atilt_pkg::*;

    function automatic lane_t step_lane(input lane_t l, input logic [STEP_W-1:0] i);
        lane_t                    r;
        logic signed [CORD_W-1:0] dx;
        logic signed [CORD_W-1:0] dy;
        logic signed [ANG_W-1:0]  da;
        dx = l.py >>> i;
        dy = l.px >>> i;
        da = atan_entry(i);
        // rotate toward the x axis
        if (!l.py[CORD_W-1] && (l.py != '0))
        begin
            r.px  = l.px + dx;
            r.py  = l.py - dy;
            r.ang = l.ang + da;
        end
        else
        begin
            r.px  = l.px - dx;
            r.py  = l.py + dy;
            r.ang = l.ang - da;
        end
        return r;
    endfunction

    logic  valid_reg;
    cord_t data_reg;
    cord_t data_next;

    always_comb
    begin
        data_next       = i_data;
        data_next.alt   = step_lane(i_data.alt, step);
        data_next.az    = step_lane(i_data.az, step);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= i_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign o_valid = valid_reg;
    assign o_data  = data_reg;

endmodule

@@ design/accel_tilt_angles_top.sv @@
// ----------------------------------------------------------------------------
// accel_tilt_angles_top
// Tilt angles from one three-axis accelerometer sample.
//
// sample (sink): one request carries accel_x/y/z in signed raw counts; it is
// taken at a clock edge with valid and ready both high. The offset registers
// (written over cfg_wen/cfg_index/cfg_data) are subtracted first.
// angles (source): one request per sample with altitude_deg and azimuth_deg,
// signed, in 1/128 degree, in sample order.
// Throughput is one sample per clock while the receiver takes the results. The
// latency is set by the pipeline depth:
// the 31 root-digit cells of the square root and the 24 CORDIC cells
// dominate, plus the front end, normalizers and rounding stages.
// When the receiver holds ready low with a result waiting, the whole pipeline
// holds and sample.ready drops in the same cycle; nothing is lost.
// Reset clears all pipeline valid bits and sets the offsets to zero. The user
// sees that configuration is written while no sample is in flight; unchecked.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module accel_tilt_angles_top (
    input  logic                            clk,
    input  logic                            rst_n,
    atilt_in_if.sink                        sample,
    atilt_out_if.source                     angles,
    input  logic                            cfg_wen,
    input  logic [atilt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [atilt_pkg::SAMPLE_W-1:0]  cfg_data
);
    import atilt_pkg::*;

    localparam logic signed [ALT_W-1:0] ALT_LIM = ALT_W'(90 * (2 ** ANGLE_FRAC));
    localparam logic signed [AZ_W-1:0]  AZ_LIM  = AZ_W'(180 * (2 ** ANGLE_FRAC));

    function automatic logic [TH_W-1:0] clamp_ang(input logic signed [ANG_W-1:0] a);
        logic [TH_W-1:0] r;
        if (a[ANG_W-1])
        begin
            r = '0;
        end
        else if (a[TH_W-1:0] > DEG90)
        begin
            r = DEG90;
        end
        else
        begin
            r = a[TH_W-1:0];
        end
        return r;
    endfunction

    logic en;

    logic signed [SAMPLE_W-1:0] off_x_reg;
    logic signed [SAMPLE_W-1:0] off_y_reg;
    logic signed [SAMPLE_W-1:0] off_z_reg;

    // offset subtract
    logic                     v0_reg;
    logic signed [DIFF_W-1:0] x0_reg;
    logic signed [DIFF_W-1:0] y0_reg;
    logic signed [DIFF_W-1:0] z0_reg;

    // magnitudes
    logic                     v1_reg;
    logic signed [DIFF_W-1:0] abs_x;
    logic signed [DIFF_W-1:0] abs_y;
    logic signed [DIFF_W-1:0] abs_z;
    logic [MAG_W-1:0]         ax1_reg;
    logic [MAG_W-1:0]         ay1_reg;
    logic [MAG_W-1:0]         az1_reg;
    flag_t                    fl1_reg;
    flag_t                    fl1_next;

    // squares
    logic             v2_reg;
    logic [SQ_W-1:0]  sqx2_reg;
    logic [SQ_W-1:0]  sqz2_reg;
    logic [MAG_W-1:0] ax2_reg;
    logic [MAG_W-1:0] ay2_reg;
    logic [MAG_W-1:0] az2_reg;
    flag_t            fl2_reg;

    // sum of squares
    logic             v3_reg;
    logic [SUM_W-1:0] sum3;
    sq_t              sq3_reg;
    sq_t              sq3_next;

    // stage chains
    logic  kv [KN+1];
    sq_t   kd [KN+1];
    logic  sv [ROOT_W+1];
    sq_t   sd [ROOT_W+1];
    logic  nv [NN+1];
    norm_t nd [NN+1];
    logic  qv [STEPS+1];
    cord_t qd [STEPS+1];

    // operand setup for the arctangents
    logic  cv_reg;
    norm_t cd_reg;
    norm_t cd_next;

    // angle select
    logic            vf1_reg;
    logic [TH_W-1:0] th_alt1_reg;
    logic [TH_W-1:0] th_az1_reg;
    flag_t           fl_f1_reg;

    logic            vf2_reg;
    logic [TH_W-1:0] mag_alt2_reg;
    logic [TH_W-1:0] mag_az2_reg;
    logic            neg_alt2_reg;
    logic            neg_az2_reg;
    logic [TH_W-1:0] mag_az2_next;

    // rounding and output
    logic [TH_W:0]            rs_alt;
    logic [TH_W:0]            rs_az;
    logic [TH_W:0]            rsh_alt;
    logic [TH_W:0]            rsh_az;
    logic [ALT_W-1:0]         r_alt;
    logic [AZ_W-1:0]          r_az;
    logic                     out_valid_reg;
    logic signed [ALT_W-1:0]  alt_reg;
    logic signed [AZ_W-1:0]   az_reg;

    assign en           = !out_valid_reg || angles.ready;
    assign sample.ready = en;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_x_reg <= '0;
            off_y_reg <= '0;
            off_z_reg <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_OFFSET_X: off_x_reg <= cfg_data;
                REG_OFFSET_Y: off_y_reg <= cfg_data;
                REG_OFFSET_Z: off_z_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // front end valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= sample.valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_comb
    begin
        abs_x           = x0_reg[DIFF_W-1] ? -x0_reg : x0_reg;
        abs_y           = y0_reg[DIFF_W-1] ? -y0_reg : y0_reg;
        abs_z           = z0_reg[DIFF_W-1] ? -z0_reg : z0_reg;
        fl1_next.y_neg  = y0_reg[DIFF_W-1];
        fl1_next.x_neg  = x0_reg[DIFF_W-1];
        fl1_next.z_neg  = z0_reg[DIFF_W-1];
        fl1_next.y_zero = (y0_reg == '0);
        fl1_next.x_zero = (x0_reg == '0);
        fl1_next.z_zero = (z0_reg == '0);
        fl1_next.s_zero = 1'b0;
    end

    always_comb
    begin
        sum3                  = SUM_W'(sqx2_reg) + SUM_W'(sqz2_reg);
        sq3_next.rad          = RAD_W'(sum3);
        sq3_next.root         = '0;
        sq3_next.rem          = '0;
        sq3_next.ax           = ax2_reg;
        sq3_next.ay           = ay2_reg;
        sq3_next.az           = az2_reg;
        sq3_next.k            = '0;
        sq3_next.flags        = fl2_reg;
        sq3_next.flags.s_zero = (sum3 == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg   <= DIFF_W'(sample.accel_x) - DIFF_W'(off_x_reg);
            y0_reg   <= DIFF_W'(sample.accel_y) - DIFF_W'(off_y_reg);
            z0_reg   <= DIFF_W'(sample.accel_z) - DIFF_W'(off_z_reg);
            ax1_reg  <= abs_x[MAG_W-1:0];
            ay1_reg  <= abs_y[MAG_W-1:0];
            az1_reg  <= abs_z[MAG_W-1:0];
            fl1_reg  <= fl1_next;
            sqx2_reg <= ax1_reg * ax1_reg;
            sqz2_reg <= az1_reg * az1_reg;
            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
            az2_reg  <= az1_reg;
            fl2_reg  <= fl1_reg;
            sq3_reg  <= sq3_next;
        end
    end

    // radicand normalization, shifting by bit pairs
    assign kv[0] = v3_reg;
    assign kd[0] = sq3_reg;

    for (genvar j = 0; j < KN; j++)
    begin : g_knorm
        localparam int AMT = 2 ** (KN - 1 - j);
        logic v_reg;
        sq_t  d_reg;
        sq_t  d_next;

        always_comb
        begin
            d_next = kd[j];
            if (kd[j].rad[RAD_W-1 -: 2*AMT] == '0)
            begin
                d_next.rad = kd[j].rad << (2 * AMT);
                d_next.k   = kd[j].k + K_W'(AMT);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= kv[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg <= d_next;
            end
        end

        assign kv[j+1] = v_reg;
        assign kd[j+1] = d_reg;
    end

    // square root, one root bit per cell
    assign sv[0] = kv[KN];
    assign sd[0] = kd[KN];

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_sqrt
        atilt_sqrt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .i_valid (sv[j]),
            .i_data  (sd[j]),
            .o_valid (sv[j+1]),
            .o_data  (sd[j+1])
        );
    end

    always_comb
    begin
        cd_next.alt_a = NORM_W'(sd[ROOT_W].ay) << sd[ROOT_W].k;
        cd_next.alt_b = NORM_W'(sd[ROOT_W].root);
        cd_next.az_a  = NORM_W'(sd[ROOT_W].ax);
        cd_next.az_b  = NORM_W'(sd[ROOT_W].az);
        cd_next.flags = sd[ROOT_W].flags;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg <= 1'b0;
        end
        else if (en)
        begin
            cv_reg <= sv[ROOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cd_reg <= cd_next;
        end
    end

    // operand normalization for the arctangents
    assign nv[0] = cv_reg;
    assign nd[0] = cd_reg;

    for (genvar j = 0; j < NN; j++)
    begin : g_anorm
        atilt_norm_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .amount  (NSH_W'(2 ** (NN - 1 - j))),
            .i_valid (nv[j]),
            .i_data  (nd[j]),
            .o_valid (nv[j+1]),
            .o_data  (nd[j+1])
        );
    end

    // vectoring cordic, x from the adjacent side, y from the opposite side
    assign qv[0]        = nv[NN];
    assign qd[0].alt.px = $signed(CORD_W'(nd[NN].alt_b));
    assign qd[0].alt.py = $signed(CORD_W'(nd[NN].alt_a));
    assign qd[0].alt.ang = '0;
    assign qd[0].az.px  = $signed(CORD_W'(nd[NN].az_b));
    assign qd[0].az.py  = $signed(CORD_W'(nd[NN].az_a));
    assign qd[0].az.ang = '0;
    assign qd[0].flags  = nd[NN].flags;

    for (genvar j = 0; j < STEPS; j++)
    begin : g_cordic
        atilt_cordic_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .step    (STEP_W'(j)),
            .i_valid (qv[j]),
            .i_data  (qd[j]),
            .o_valid (qv[j+1]),
            .o_data  (qd[j+1])
        );
    end

    // quadrant fixup, rounding and output register
    always_comb
    begin
        if (fl_f1_reg.x_zero && fl_f1_reg.z_zero)
        begin
            mag_az2_next = '0;
        end
        else if (fl_f1_reg.z_neg)
        begin
            mag_az2_next = DEG180 - th_az1_reg;
        end
        else
        begin
            mag_az2_next = th_az1_reg;
        end
    end

    always_comb
    begin
        rs_alt  = {1'b0, mag_alt2_reg} + (TH_W + 1)'(2 ** (RND_SH - 1));
        rs_az   = {1'b0, mag_az2_reg} + (TH_W + 1)'(2 ** (RND_SH - 1));
        rsh_alt = rs_alt >> RND_SH;
        rsh_az  = rs_az >> RND_SH;
        r_alt   = rsh_alt[ALT_W-1:0];
        r_az    = rsh_az[AZ_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf1_reg       <= 1'b0;
            vf2_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vf1_reg       <= qv[STEPS];
            vf2_reg       <= vf1_reg;
            out_valid_reg <= vf2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (qd[STEPS].flags.y_zero)
            begin
                th_alt1_reg <= '0;
            end
            else if (qd[STEPS].flags.s_zero)
            begin
                th_alt1_reg <= DEG90;
            end
            else
            begin
                th_alt1_reg <= clamp_ang(qd[STEPS].alt.ang);
            end
            if (qd[STEPS].flags.x_zero)
            begin
                th_az1_reg <= '0;
            end
            else if (qd[STEPS].flags.z_zero)
            begin
                th_az1_reg <= DEG90;
            end
            else
            begin
                th_az1_reg <= clamp_ang(qd[STEPS].az.ang);
            end
            fl_f1_reg    <= qd[STEPS].flags;
            mag_alt2_reg <= th_alt1_reg;
            mag_az2_reg  <= mag_az2_next;
            neg_alt2_reg <= fl_f1_reg.y_neg;
            neg_az2_reg  <= fl_f1_reg.x_neg;
            alt_reg      <= neg_alt2_reg ? -r_alt : r_alt;
            az_reg       <= neg_az2_reg ? -r_az : r_az;
        end
    end

    assign angles.valid        = out_valid_reg;
    assign angles.altitude_deg = alt_reg;
    assign angles.azimuth_deg  = az_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> v0_reg)
        else $error("accepted request did not enter the pipeline");

    assert property (@(posedge clk) disable iff (!rst_n)
        sv[ROOT_W] |-> sd[ROOT_W].root[ROOT_W-1] || sd[ROOT_W].flags.s_zero)
        else $error("square root result not normalized");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> alt_reg <= ALT_LIM && alt_reg >= -ALT_LIM)
        else $error("altitude out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> az_reg <= AZ_LIM && az_reg >= -AZ_LIM)
        else $error("azimuth out of range");

endmodule
